FILE: rtl/core/fill_position_and_average_cost_tracker_core_assert.svh
// Assertion macros used by the fill position tracker controller.
`ifndef FILL_POSITION_AND_AVERAGE_COST_TRACKER_CORE_ASSERT_SVH
`define FILL_POSITION_AND_AVERAGE_COST_TRACKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication checked at every clock edge outside reset.
`define FPACT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fpact assertion failed");
// Next-cycle implication checked at every clock edge outside reset.
`define FPACT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fpact assertion failed");
`else
`define FPACT_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define FPACT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/fpact_pkg.sv
// Types and constants shared by the fill position tracker modules.
package fpact_pkg;

    localparam int SLOT_W  = 10;
    localparam int INST_W  = 6;
    localparam int POS_W   = 24;
    localparam int FILL_W  = 23;
    localparam int PRICE_W = 48;
    localparam int OWN_W   = 8;
    localparam int ACC_W   = 72;
    localparam int DIVR_W  = 25;

    localparam int ORDER_SLOTS_DEF = 1024;
    localparam int INSTRUMENTS_DEF = 64;

    // Input beat layout, lowest bit first.
    localparam int I_SLOT   = 0;
    localparam int I_OPRES  = 10;
    localparam int I_INST   = 11;
    localparam int I_IPRES  = 17;
    localparam int I_BUY    = 18;
    localparam int I_CUM    = 19;
    localparam int I_PRICE  = 43;
    localparam int I_FIN    = 91;
    localparam int I_OPEN   = 92;
    localparam int I_STRAT  = 93;
    localparam int I_SPRES  = 101;
    localparam int IN_TDATA_W = 104;

    // Result beat layout, lowest bit first.
    localparam int O_APPL   = 0;
    localparam int O_POS    = 1;
    localparam int O_AVG    = 25;
    localparam int O_AVGV   = 73;
    localparam int O_OWN    = 74;
    localparam int O_OWNV   = 82;
    localparam int OUT_TDATA_W = 88;

    // One instrument entry.
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [PRICE_W-1:0] avg;
        logic               avg_held;
        logic [OWN_W-1:0]   own;
        logic               own_held;
    } inst_rec_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic load;
        logic eval;
        logic mul;
        logic div_start;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic need_div;
        logic mul_last;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/core/fpact_div.sv
// Radix-4 restoring divider for the weighted average.
module fpact_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [fpact_pkg::ACC_W-1:0]      dividend,
    input  logic [fpact_pkg::DIVR_W-1:0]     divisor,
    output logic                             done,
    output logic [fpact_pkg::PRICE_W-1:0]    quotient
);
    import fpact_pkg::*;

    localparam int STEPS = ACC_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [ACC_W-1:0]   dvd_reg;
    logic [DIVR_W-1:0]  rem_reg;
    logic [PRICE_W-1:0] q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIVR_W:0]    t1, t2;
    logic [DIVR_W-1:0]  r1, r2;
    logic               q1, q2;

    // Two quotient bits per cycle.
    always_comb begin
        t1 = {rem_reg, dvd_reg[ACC_W-1]};
        q1 = (t1 >= {1'b0, divisor});
        r1 = q1 ? DIVR_W'(t1 - {1'b0, divisor}) : t1[DIVR_W-1:0];
        t2 = {r1, dvd_reg[ACC_W-2]};
        q2 = (t2 >= {1'b0, divisor});
        r2 = q2 ? DIVR_W'(t2 - {1'b0, divisor}) : t2[DIVR_W-1:0];
    end

    // Iteration registers and the done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            q_reg   <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[ACC_W-3:0], 2'b00};
            rem_reg <= r2;
            q_reg   <= {q_reg[PRICE_W-3:0], q1, q2};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/core/fpact_ctrl.sv
// Controller state machine that sequences one fill report at a time.
`include "fill_position_and_average_cost_tracker_core_assert.svh"
module fpact_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  fpact_pkg::sts_t  sts,
    output fpact_pkg::cmd_t  cmd
);
    import fpact_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_EVAL  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_DGO   = 8'b0010_0000,
        ST_DWAIT = 8'b0100_0000,
        ST_WRITE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (sts.clear_done) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_READ;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:  state_next = sts.need_div ? ST_MUL : ST_WRITE;
            ST_MUL:   if (sts.mul_last) state_next = ST_DGO;
            ST_DGO:   state_next = ST_DWAIT;
            ST_DWAIT: if (sts.div_done) state_next = ST_WRITE;
            ST_WRITE: if (sts.out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands decoded from the state.
    always_comb begin
        cmd.clear_en  = (state_reg == ST_CLEAR);
        cmd.load      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.eval      = (state_reg == ST_EVAL);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.div_start = (state_reg == ST_DGO);
        cmd.commit    = (state_reg == ST_WRITE) && sts.out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);

    `FPACT_ASSERT_NEXT(a_accept_reads, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_READ)
    `FPACT_ASSERT_NEXT(a_div_waits, aclk, aresetn, cmd.div_start, state_reg == ST_DWAIT)
    `FPACT_ASSERT_NOW(a_done_in_wait, aclk, aresetn, sts.div_done, state_reg == ST_DWAIT)
    `FPACT_ASSERT_NEXT(a_commit_idle, aclk, aresetn, cmd.commit, state_reg == ST_IDLE)

endmodule

FILE: rtl/core/fpact_dp.sv
// Datapath: tables, case decisions, weighted sum and the result register.
module fpact_dp #(
    parameter int ORDER_SLOTS = fpact_pkg::ORDER_SLOTS_DEF,
    parameter int INSTRUMENTS = fpact_pkg::INSTRUMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fpact_pkg::cmd_t                     cmd,
    output fpact_pkg::sts_t                     sts,
    input  logic [fpact_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fpact_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import fpact_pkg::*;

    localparam int OW = $clog2(ORDER_SLOTS);
    localparam int IW = $clog2(INSTRUMENTS);
    localparam int CLR_DEPTH = (ORDER_SLOTS > INSTRUMENTS) ? ORDER_SLOTS : INSTRUMENTS;
    localparam int CW = $clog2(CLR_DEPTH);

    // Input beat holding register and its fields.
    logic [IN_TDATA_W-1:0] in_reg;
    logic [SLOT_W-1:0]  f_slot;
    logic [INST_W-1:0]  f_inst;
    logic [POS_W-1:0]   f_cum;
    logic [PRICE_W-1:0] f_price;
    logic [OWN_W-1:0]   f_strat;
    logic f_opres, f_ipres, f_buy, f_fin, f_open, f_spres;

    // Memories.
    logic [FILL_W-1:0] order_mem [ORDER_SLOTS];
    inst_rec_t         inst_mem  [INSTRUMENTS];
    logic [FILL_W-1:0] order_rd_reg;
    inst_rec_t         inst_rd_reg;
    logic [OW-1:0]     order_addr;
    logic [IW-1:0]     inst_addr;
    logic              order_we, inst_we;
    logic [OW-1:0]     order_wa;
    logic [IW-1:0]     inst_wa;
    logic [FILL_W-1:0] order_wd;
    inst_rec_t         inst_wd;
    logic [CW-1:0]     clr_cnt_reg;

    // Evaluation signals.
    logic                slot_ok, inst_ok, appl;
    logic [FILL_W-1:0]   cur;
    logic signed [POS_W-1:0] delta, oldp;
    logic signed [25:0]  oldp_w, newp, abs_old_w, abs_new_w;
    logic [POS_W-1:0]    stored;
    logic                is_zero, is_flip, grow, own_set;
    logic [PRICE_W-1:0]  old_avg;
    inst_rec_t           rec_new;

    // Registered results of the evaluation.
    logic                appl_reg, inst_ok_reg, div_reg;
    logic [FILL_W-1:0]   cur_reg;
    inst_rec_t           rec_reg;
    logic [23:0]         abs_old_reg, delta_reg;
    logic [DIVR_W-1:0]   abs_new_reg;
    logic [PRICE_W-1:0]  old_avg_reg, price_reg;

    // Multiply and accumulate sequencing.
    logic [2:0]          mul_cnt_reg;
    logic [47:0]         prod_reg;
    logic                prod_hi_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [PRICE_W-1:0]  mul_x;
    logic [23:0]         mul_a, mul_b;

    logic                div_done;
    logic [PRICE_W-1:0]  quotient;
    inst_rec_t           rec_fin;
    logic                m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    assign f_slot  = in_reg[I_SLOT +: SLOT_W];
    assign f_opres = in_reg[I_OPRES];
    assign f_inst  = in_reg[I_INST +: INST_W];
    assign f_ipres = in_reg[I_IPRES];
    assign f_buy   = in_reg[I_BUY];
    assign f_cum   = in_reg[I_CUM +: POS_W];
    assign f_price = in_reg[I_PRICE +: PRICE_W];
    assign f_fin   = in_reg[I_FIN];
    assign f_open  = in_reg[I_OPEN];
    assign f_strat = in_reg[I_STRAT +: OWN_W];
    assign f_spres = in_reg[I_SPRES];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_tdata;
        end
    end

    assign order_addr = OW'(f_slot);
    assign inst_addr  = IW'(f_inst);

    // Clearing pass counter after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_en && clr_cnt_reg != CW'(CLR_DEPTH - 1)) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clear_done = (clr_cnt_reg == CW'(CLR_DEPTH - 1));

    // Write port selection: clearing pass or commit of an applied report.
    always_comb begin
        order_we = 1'b0;
        inst_we  = 1'b0;
        order_wa = order_addr;
        inst_wa  = inst_addr;
        order_wd = cur_reg;
        inst_wd  = rec_fin;
        if (cmd.clear_en) begin
            order_we = (32'(clr_cnt_reg) < ORDER_SLOTS);
            inst_we  = (32'(clr_cnt_reg) < INSTRUMENTS);
            order_wa = OW'(clr_cnt_reg);
            inst_wa  = IW'(clr_cnt_reg);
            order_wd = '0;
            inst_wd  = '0;
        end else if (cmd.commit) begin
            order_we = appl_reg;
            inst_we  = appl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[order_wa] <= order_wd;
        end
        order_rd_reg <= order_mem[order_addr];
    end

    always_ff @(posedge aclk) begin
        if (inst_we) begin
            inst_mem[inst_wa] <= inst_wd;
        end
        inst_rd_reg <= inst_mem[inst_addr];
    end

    // Case decisions on the report and the stored entries.
    always_comb begin
        slot_ok   = f_opres && (32'(f_slot) < ORDER_SLOTS);
        inst_ok   = f_ipres && (32'(f_inst) < INSTRUMENTS);
        cur       = f_cum[POS_W-1] ? '0 : f_cum[FILL_W-1:0];
        delta     = POS_W'({1'b0, cur}) - POS_W'({1'b0, order_rd_reg});
        appl      = slot_ok && inst_ok && f_fin && !delta[POS_W-1] && (delta != '0);
        oldp      = inst_rd_reg.pos;
        oldp_w    = 26'(oldp);
        newp      = f_buy ? (oldp_w + 26'(delta)) : (oldp_w - 26'(delta));
        abs_old_w = oldp_w[25] ? -oldp_w : oldp_w;
        abs_new_w = newp[25] ? -newp : newp;
        if (newp > 26'sd8388607) begin
            stored = 24'h7F_FFFF;
        end else if (newp < -26'sd8388608) begin
            stored = 24'h80_0000;
        end else begin
            stored = newp[POS_W-1:0];
        end
        is_zero = (newp == '0);
        is_flip = (oldp == '0) || ((oldp > 0) != (newp > 0));
        grow    = abs_new_w > abs_old_w;
        old_avg = inst_rd_reg.avg_held ? inst_rd_reg.avg : f_price;
        own_set = !is_zero && f_spres && (f_open || !inst_rd_reg.own_held);

        rec_new = inst_rd_reg;
        if (appl) begin
            rec_new.pos = stored;
            if (is_zero) begin
                rec_new.avg_held = 1'b0;
                rec_new.own_held = 1'b0;
            end else begin
                rec_new.avg      = is_flip ? f_price : old_avg;
                rec_new.avg_held = 1'b1;
            end
            if (own_set) begin
                rec_new.own      = f_strat;
                rec_new.own_held = 1'b1;
            end
        end
    end

    assign sts.need_div = appl && !is_zero && !is_flip && grow;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            appl_reg    <= appl;
            inst_ok_reg <= inst_ok;
            div_reg     <= sts.need_div;
            cur_reg     <= cur;
            rec_reg     <= rec_new;
            abs_old_reg <= abs_old_w[23:0];
            abs_new_reg <= abs_new_w[DIVR_W-1:0];
            delta_reg   <= delta;
            old_avg_reg <= old_avg;
            price_reg   <= f_price;
        end
    end

    // Four 24x24 partial products, each registered, then accumulated.
    always_comb begin
        mul_x = mul_cnt_reg[1] ? price_reg : old_avg_reg;
        mul_a = mul_cnt_reg[0] ? mul_x[47:24] : mul_x[23:0];
        mul_b = mul_cnt_reg[1] ? delta_reg : abs_old_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            mul_cnt_reg <= '0;
            acc_reg     <= '0;
        end else if (cmd.mul) begin
            mul_cnt_reg <= mul_cnt_reg + 1'b1;
            prod_reg    <= mul_a * mul_b;
            prod_hi_reg <= mul_cnt_reg[0];
            if (mul_cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + (prod_hi_reg ? {prod_reg, 24'd0} : ACC_W'(prod_reg));
            end
        end
    end

    assign sts.mul_last = (mul_cnt_reg == 3'd4);

    fpact_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (abs_new_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sts.div_done = div_done;

    always_comb begin
        rec_fin = rec_reg;
        if (div_reg) begin
            rec_fin.avg = quotient;
        end
    end

    // Result register; the next report may enter while a beat waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result beat assembled from the finished entry.
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[O_APPL] = appl_reg;
        if (inst_ok_reg) begin
            m_tdata_next[O_POS +: POS_W]   = rec_fin.pos;
            m_tdata_next[O_AVG +: PRICE_W] = rec_fin.avg_held ? rec_fin.avg : '0;
            m_tdata_next[O_AVGV]           = rec_fin.avg_held;
            m_tdata_next[O_OWN +: OWN_W]   = rec_fin.own_held ? rec_fin.own : '0;
            m_tdata_next[O_OWNV]           = rec_fin.own_held;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/fill_position_and_average_cost_tracker_core.sv
// Fill position and weighted-average-cost tracker, top level.
//
// Slave channel s_*: one fill report per beat. Master channel m_*: one
// result per report, in report order. Reports are handled one at a time.
// After a report is taken, it passes through the read, evaluate and
// write states, and its result is loaded into the output register when
// the average is kept, set or cleared. When a same-side position grows,
// the weighted sum is built from four registered 24x24 partial products
// and divided by a two-bits-per-cycle restoring divider before the write.
// The next report is taken the cycle after a result is loaded into the
// output register, even if that result still waits for m_tready.
// After reset a clearing pass writes every order and instrument entry
// with s_tready low. When the receiver stalls, the finished result holds
// in the output register and the following report waits in its final
// cycle until the register is free.
module fill_position_and_average_cost_tracker_core #(
    parameter int ORDER_SLOTS = fpact_pkg::ORDER_SLOTS_DEF,
    parameter int INSTRUMENTS = fpact_pkg::INSTRUMENTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // order_slot, order_present, instrument, instrument_present, is_buy,
    // cumulative_filled, price, price_finite, opens_position,
    // strategy, strategy_present
    input  logic [fpact_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // applied, position, average_price, average_valid, owner, owner_valid
    output logic [fpact_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import fpact_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fpact_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpact_dp #(
        .ORDER_SLOTS (ORDER_SLOTS),
        .INSTRUMENTS (INSTRUMENTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
